[design/api_frame_receiver_dispatch_defines.svh]
// Assertion macros used by the frame receiver top level.
`ifndef API_FRAME_RECEIVER_DISPATCH_DEFINES_SVH
`define API_FRAME_RECEIVER_DISPATCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define AFRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afrd check failed");
// Next-cycle implication, held off during reset.
`define AFRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afrd check failed");
`else
`define AFRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define AFRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/afrd_pkg.sv]
// Shared types and constants of the frame receiver and dispatcher.
package afrd_pkg;

  localparam int STORE_BYTES_DEF = 128;
  localparam int MAX_PARAMS_DEF  = 10;

  localparam logic [7:0] START_DELIM    = 8'h7E;
  localparam logic [7:0] SUM_GOOD       = 8'hFF;
  localparam logic [7:0] NO_ACK_ID      = 8'hFF;
  localparam logic [7:0] FRAME_TYPE_RST = 8'hB0;

  localparam int PAYLOAD_AT = 14;  // first payload byte in the frame store
  localparam int SUM_FROM   = 3;   // checksum covers bytes from here on
  localparam int HDR_BYTES  = 5;   // id, type, tag, count lo, count hi
  localparam int WORD_BYTES = 4;
  localparam int TOK_DEPTH  = 2;   // frames waiting for dispatch

  localparam logic [1:0] KIND_CTRL  = 2'd0;
  localparam logic [1:0] KIND_CAR   = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  typedef struct packed {
    logic        is_header;
    logic [7:0]  msg_id;
    logic [1:0]  packet_kind;
    logic [7:0]  tag_byte;
    logic [15:0] param_count;
    logic        ack_request;
    logic [31:0] param_word;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HDR_RD,
    BK_HDR_OUT,
    BK_WD_RD,
    BK_WD_OUT
  } bk_state_t;

  typedef struct packed {
    logic pending;     // at least one frame queued or being dispatched
    logic queue_full;  // no room for another finished frame
  } bk_status_t;

endpackage

[design/afrd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module afrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/afrd_front.sv]
// Byte parser: delimiter hunt, store writes, length, checksum and type check.
module afrd_front #(
  parameter int STORE_BYTES = 128,
  localparam int ADDR_W = $clog2(STORE_BYTES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             frame_type,
  input  afrd_pkg::bk_status_t   bk_status,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [7:0]             wr_data,
  output logic                   tok_push
);
  import afrd_pkg::*;

  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        type_r, type_nxt;
  logic              acc;
  logic [ADDR_W:0]   pos_inc;
  logic [7:0]        sum_base;
  logic [7:0]        type_eff;

  // Bytes that land at or past the payload must wait until the store is free.
  assign full = bk_status.queue_full ||
                (bk_status.pending && (pos_r >= ADDR_W'(PAYLOAD_AT)));
  assign acc  = push && !full;

  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign sum_base = (pos_r == '0) ? 8'h00 : sum_r;
  assign type_eff = (pos_r == ADDR_W'(SUM_FROM)) ? rx_byte : type_r;
  assign wr_addr  = pos_r;
  assign wr_data  = rx_byte;

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    type_nxt = type_r;
    wr_en    = 1'b0;
    tok_push = 1'b0;
    if (acc && !((pos_r == '0) && (rx_byte != START_DELIM))) begin
      wr_en   = 1'b1;
      sum_nxt = (pos_r >= ADDR_W'(SUM_FROM)) ? sum_base + rx_byte : sum_base;
      if (pos_r == ADDR_W'(1)) begin
        len_nxt[15:8] = rx_byte;
      end
      if (pos_r == ADDR_W'(2)) begin
        len_nxt[7:0] = rx_byte;
      end
      if (pos_r == ADDR_W'(SUM_FROM)) begin
        type_nxt = rx_byte;
      end
      if (pos_inc == (ADDR_W+1)'(STORE_BYTES)) begin
        pos_nxt = '0;  // store overflow: drop the frame
      end else if (17'(pos_inc) == {1'b0, len_r} + 17'd4) begin
        pos_nxt  = '0;
        tok_push = (sum_nxt == SUM_GOOD) && (type_eff == frame_type);
      end else begin
        pos_nxt = pos_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      type_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
    end
  end

endmodule

[design/afrd_back.sv]
// Dispatcher: reads payload bytes of a finished frame and builds result items.
module afrd_back #(
  parameter int STORE_BYTES = 128,
  parameter int MAX_PARAMS  = 10,
  localparam int ADDR_W = $clog2(STORE_BYTES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tok_push,
  output afrd_pkg::bk_status_t   status,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  logic [7:0]             rd_byte,
  input  logic                   oq_full,
  output logic                   oq_push,
  output afrd_pkg::out_item_t    oq_item
);
  import afrd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);

  bk_state_t         state_r, state_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [2:0]        iss_r, iss_nxt;
  logic [2:0]        got_r, got_nxt;
  logic              rdp_r, rdp_nxt;
  logic [39:0]       sr_r, sr_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              done;
  logic [2:0]        grp;
  logic [1:0]        kind;
  logic [15:0]       cnt;
  logic [15:0]       nwords16;
  logic [CNT_W-1:0]  nwords;

  assign status.pending    = (pend_r != 2'd0);
  assign status.queue_full = (pend_r == 2'(TOK_DEPTH));
  assign rd_addr           = addr_r;

  // Header fields, valid in BK_HDR_OUT
  always_comb begin
    case (sr_r[15:8])
      8'd0:    kind = KIND_CTRL;
      8'd1:    kind = KIND_CAR;
      default: kind = KIND_OTHER;
    endcase
    cnt      = (kind == KIND_OTHER) ? 16'h0000 : sr_r[39:24];
    nwords16 = (cnt < 16'(MAX_PARAMS)) ? cnt : 16'(MAX_PARAMS);
    nwords   = nwords16[CNT_W-1:0];
  end

  assign grp = (state_r == BK_HDR_RD) ? 3'(HDR_BYTES) : 3'(WORD_BYTES);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    iss_nxt   = iss_r;
    got_nxt   = got_r;
    rdp_nxt   = 1'b0;
    sr_nxt    = sr_r;
    left_nxt  = left_r;
    done      = 1'b0;
    rd_en     = 1'b0;
    oq_push   = 1'b0;
    oq_item   = '0;
    case (state_r)
      BK_IDLE: begin
        if (pend_r != 2'd0) begin
          addr_nxt  = ADDR_W'(PAYLOAD_AT);
          iss_nxt   = '0;
          got_nxt   = '0;
          state_nxt = BK_HDR_RD;
        end
      end
      BK_HDR_RD, BK_WD_RD: begin
        if (iss_r < grp) begin
          rd_en    = 1'b1;
          rdp_nxt  = 1'b1;
          addr_nxt = addr_r + 1'b1;
          iss_nxt  = iss_r + 1'b1;
        end
        if (rdp_r) begin
          sr_nxt  = {rd_byte, sr_r[39:8]};
          got_nxt = got_r + 1'b1;
          if (got_r == grp - 1'b1) begin
            iss_nxt   = '0;
            got_nxt   = '0;
            state_nxt = (state_r == BK_HDR_RD) ? BK_HDR_OUT : BK_WD_OUT;
          end
        end
      end
      BK_HDR_OUT: begin
        oq_item.is_header   = 1'b1;
        oq_item.msg_id      = sr_r[7:0];
        oq_item.packet_kind = kind;
        oq_item.tag_byte    = (kind == KIND_OTHER) ? 8'h00 : sr_r[23:16];
        oq_item.param_count = cnt;
        oq_item.ack_request = (sr_r[7:0] != NO_ACK_ID);
        oq_item.last        = (nwords == '0);
        if (!oq_full) begin
          oq_push  = 1'b1;
          left_nxt = nwords;
          if (nwords == '0) begin
            done      = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_WD_RD;
          end
        end
      end
      BK_WD_OUT: begin
        oq_item.param_word = sr_r[39:8];
        oq_item.last       = (left_r == CNT_W'(1));
        if (!oq_full) begin
          oq_push  = 1'b1;
          left_nxt = left_r - 1'b1;
          if (left_r == CNT_W'(1)) begin
            done      = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_WD_RD;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    pend_nxt = 2'(pend_r + {1'b0, tok_push} - {1'b0, done});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pend_r  <= '0;
      iss_r   <= '0;
      got_r   <= '0;
      rdp_r   <= 1'b0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      iss_r   <= iss_nxt;
      got_r   <= got_nxt;
      rdp_r   <= rdp_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    sr_r   <= sr_nxt;
  end

endmodule

[design/afrd_outq.sv]
// Two-entry result queue with push/full and pop/empty sides.
module afrd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  afrd_pkg::out_item_t  push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output afrd_pkg::out_item_t  head
);
  import afrd_pkg::*;

  out_item_t  ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

[design/api_frame_receiver_dispatch.sv]
// Top level: start-delimited frame receiver with payload dispatch.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | push / full            | in_rx_byte
//  result   | empty / pop            | out_is_header .. out_last (8 fields)
//  config   | cfg_we (write only)    | cfg_wdata -> accepted frame type
//
// A frame that passes its checksum and type check is handed to the
// dispatcher, which reads the payload from the frame store one byte per
// cycle over its single read port for a header plus N parameter words
// (N <= MAX_PARAMS), pausing between items while the result queue is full.
// While a dispatch is pending, the next frame is taken up to the first payload
// byte, then full holds until the store is free again. Reset is synchronous;
// store entries read as zero until written (one valid flop per entry), so no
// clearing pass is needed. A stalled result side stops the dispatcher, then
// the input side; up to two finished frames can wait for it.
`include "api_frame_receiver_dispatch_defines.svh"

module api_frame_receiver_dispatch #(
  parameter int STORE_BYTES = afrd_pkg::STORE_BYTES_DEF,
  parameter int MAX_PARAMS  = afrd_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  // result item channel
  output logic        empty,
  input  logic        pop,
  output logic        out_is_header,
  output logic [7:0]  out_msg_id,
  output logic [1:0]  out_packet_kind,
  output logic [7:0]  out_tag_byte,
  output logic [15:0] out_param_count,
  output logic        out_ack_request,
  output logic [31:0] out_param_word,
  output logic        out_last,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import afrd_pkg::*;

  localparam int ADDR_W = $clog2(STORE_BYTES);

  logic [7:0]             frame_type_r;
  bk_status_t             bk_status;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [7:0]             wr_data;
  logic                   tok_push;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [7:0]             ram_q;
  logic [7:0]             rd_byte;
  logic [STORE_BYTES-1:0] vld_r;
  logic                   rd_vld_r;
  logic                   oq_full;
  logic                   oq_push;
  out_item_t              oq_item;
  out_item_t              head;

  // Accepted frame type register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= FRAME_TYPE_RST;
    end else if (cfg_we) begin
      frame_type_r <= cfg_wdata;
    end
  end

  afrd_front #(.STORE_BYTES(STORE_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .rx_byte    (in_rx_byte),
    .frame_type (frame_type_r),
    .bk_status  (bk_status),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .tok_push   (tok_push)
  );

  // Frame store; entries never written since reset read as zero
  afrd_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_byte = rd_vld_r ? ram_q : 8'h00;

  afrd_back #(.STORE_BYTES(STORE_BYTES), .MAX_PARAMS(MAX_PARAMS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_push (tok_push),
    .status   (bk_status),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_byte  (rd_byte),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_item  (oq_item)
  );

  afrd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_item),
    .full      (oq_full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign out_is_header   = head.is_header;
  assign out_msg_id      = head.msg_id;
  assign out_packet_kind = head.packet_kind;
  assign out_tag_byte    = head.tag_byte;
  assign out_param_count = head.param_count;
  assign out_ack_request = head.ack_request;
  assign out_param_word  = head.param_word;
  assign out_last        = head.last;

  // The parser must never overwrite payload that a pending dispatch reads.
  `AFRD_ASSERT_NOW(a_no_payload_clobber, clk, rst_n, wr_en && bk_status.pending, wr_addr < ADDR_W'(PAYLOAD_AT))
  // The dispatcher only reads the payload region.
  `AFRD_ASSERT_NOW(a_read_in_payload, clk, rst_n, rd_en, rd_addr >= ADDR_W'(PAYLOAD_AT))
  // Results are never pushed into a full result queue.
  `AFRD_ASSERT_NOW(a_no_oq_overflow, clk, rst_n, oq_push, !oq_full)
  // A finished frame is always registered as pending dispatch.
  `AFRD_ASSERT_NEXT(a_token_taken, clk, rst_n, tok_push, bk_status.pending)

endmodule

[dv/afrd_dispatch_checker.sv]
// Frame receiver checker: predicts result items from accepted bytes and compares them.
`timescale 1ns / 1ps

module afrd_dispatch_checker #(
  parameter int STORE_BYTES = afrd_pkg::STORE_BYTES_DEF,
  parameter int MAX_PARAMS  = afrd_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_is_header,
  input  logic [7:0]  out_msg_id,
  input  logic [1:0]  out_packet_kind,
  input  logic [7:0]  out_tag_byte,
  input  logic [15:0] out_param_count,
  input  logic        out_ack_request,
  input  logic [31:0] out_param_word,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          n_fail,
  output int          n_pending,
  output int          n_predicted,
  output int          n_checked,
  output logic        rx_idle
);
  import afrd_pkg::*;

  logic [7:0] rx_store [STORE_BYTES];
  int         rx_pos;
  int         rx_len;
  logic [7:0] rx_sum;
  logic [7:0] match_type;
  out_item_t  due_results [$];

  function automatic logic [7:0] store_at(input int idx);
    return (idx < STORE_BYTES) ? rx_store[idx] : 8'h00;
  endfunction

  // Header item, then one item per parameter word.
  task automatic predict_dispatch();
    out_item_t  it;
    logic [7:0] id;
    logic [7:0] ptype;
    int         nw;
    int         base;
    id    = store_at(PAYLOAD_AT);
    ptype = store_at(PAYLOAD_AT + 1);
    it = '0;
    it.is_header   = 1'b1;
    it.msg_id      = id;
    it.packet_kind = (ptype == 8'h00) ? KIND_CTRL : (ptype == 8'h01) ? KIND_CAR : KIND_OTHER;
    it.ack_request = (id != NO_ACK_ID);
    nw = 0;
    if (it.packet_kind != KIND_OTHER) begin
      it.tag_byte    = store_at(PAYLOAD_AT + 2);
      it.param_count = {store_at(PAYLOAD_AT + 4), store_at(PAYLOAD_AT + 3)};
      nw = (it.param_count > MAX_PARAMS) ? MAX_PARAMS : int'(it.param_count);
    end
    it.last = (nw == 0);
    due_results.push_back(it);
    for (int k = 0; k < nw; k++) begin
      base = PAYLOAD_AT + HDR_BYTES + WORD_BYTES * k;
      it = '0;
      it.param_word = {store_at(base + 3), store_at(base + 2), store_at(base + 1),
                       store_at(base)};
      it.last = (k == nw - 1);
      due_results.push_back(it);
    end
    n_predicted += nw + 1;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (rx_pos == 0) begin
      if (b != START_DELIM) return;
      rx_sum = 8'h00;
    end
    rx_store[rx_pos] = b;
    if (rx_pos >= SUM_FROM) rx_sum += b;
    rx_pos++;
    // store full: drop frame, hunt for next delimiter
    if (rx_pos >= STORE_BYTES) begin
      rx_pos = 0;
      return;
    end
    if (rx_pos == 3) rx_len = int'({rx_store[1], rx_store[2]});
    if (rx_pos == rx_len + 4) begin
      if (rx_sum == SUM_GOOD && rx_store[3] == match_type) predict_dispatch();
      rx_pos = 0;
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      n_fail++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_result();
    out_item_t got;
    out_item_t want;
    got = {out_is_header, out_msg_id, out_packet_kind, out_tag_byte, out_param_count,
           out_ack_request, out_param_word, out_last};
    n_checked++;
    if (due_results.size() == 0) begin
      n_fail++;
      $display("%0t: result item with nothing expected: expected none, got 0x%0h",
               $time, got);
      return;
    end
    want = due_results.pop_front();
    field_check("is_header", 32'(want.is_header), 32'(got.is_header));
    field_check("msg_id", 32'(want.msg_id), 32'(got.msg_id));
    field_check("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
    field_check("tag_byte", 32'(want.tag_byte), 32'(got.tag_byte));
    field_check("param_count", 32'(want.param_count), 32'(got.param_count));
    field_check("ack_request", 32'(want.ack_request), 32'(got.ack_request));
    field_check("param_word", want.param_word, got.param_word);
    field_check("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) rx_store[i] = 8'h00;
      rx_pos      = 0;
      rx_len      = 0;
      rx_sum      = 8'h00;
      match_type  = FRAME_TYPE_RST;
      n_fail      = 0;
      n_predicted = 0;
      n_checked   = 0;
      due_results.delete();
    end else begin
      // results leaving now were predicted at an earlier edge
      if (pop && !empty) check_result();
      // a byte taken at this edge still sees the old frame type
      if (push && !full) take_byte(in_rx_byte);
      if (cfg_we) match_type = cfg_wdata;
    end
    n_pending = due_results.size();
    rx_idle   = (rx_pos == 0);
  end

endmodule

[dv/api_frame_receiver_dispatch_tb.sv]
// Testbench top: byte stimulus, receiver stalls and verdict for the frame receiver.
`timescale 1ns / 1ps

module api_frame_receiver_dispatch_tb;
  import afrd_pkg::*;

  // Extra wait after a drain, with margin beyond the dispatch of a full frame.
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic        out_is_header;
  logic [7:0]  out_msg_id;
  logic [1:0]  out_packet_kind;
  logic [7:0]  out_tag_byte;
  logic [15:0] out_param_count;
  logic        out_ack_request;
  logic [31:0] out_param_word;
  logic        out_last;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  int          n_fail;
  int          n_pending;
  int          n_predicted;
  int          n_checked;
  logic        rx_idle;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_len = 0;     // request for a long receiver hold-off
  int          n_bytes = 0;
  int          n_frames = 0;
  int          cycle_count = 0;
  logic [7:0]  cur_type;          // frame type the block currently accepts
  logic [7:0]  pay_q [$];         // payload bytes placed from PAYLOAD_AT on

  always #2 clk = ~clk;

  api_frame_receiver_dispatch dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_is_header   (out_is_header),
    .out_msg_id      (out_msg_id),
    .out_packet_kind (out_packet_kind),
    .out_tag_byte    (out_tag_byte),
    .out_param_count (out_param_count),
    .out_ack_request (out_ack_request),
    .out_param_word  (out_param_word),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  afrd_dispatch_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_is_header   (out_is_header),
    .out_msg_id      (out_msg_id),
    .out_packet_kind (out_packet_kind),
    .out_tag_byte    (out_tag_byte),
    .out_param_count (out_param_count),
    .out_ack_request (out_ack_request),
    .out_param_word  (out_param_word),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .n_fail          (n_fail),
    .n_pending       (n_pending),
    .n_predicted     (n_predicted),
    .n_checked       (n_checked),
    .rx_idle         (rx_idle)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL api_frame_receiver_dispatch");
      $finish;
    end
  end

  // Receiver: pops at random, or holds off for a requested number of cycles.
  initial begin
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_len > 0) begin
        hold      = stall_len;
        stall_len = 0;
      end
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One item on the input side. Called and returns just after a falling edge;
  // push is left high so back-to-back bytes never drop it for a step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push       = 1'b0;
      in_rx_byte = 8'($urandom);   // junk on the bus while idle
      @(negedge clk);
    end
    push       = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (full);
    @(negedge clk);
    n_bytes++;
  endtask

  // Stop sending and wait until every predicted item has left the block.
  task automatic drain();
    push = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Frame type register: only written with the parser hunting for a delimiter
  // and the dispatcher idle.
  task automatic write_frame_type(input logic [7:0] v);
    while (!rx_idle) send_byte(8'h00);
    drain();
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_type  = v;
  endtask

  task automatic load_payload(input logic [7:0] id, input logic [7:0] ptype,
                              input logic [7:0] tag, input logic [15:0] cnt,
                              input int nwords);
    pay_q.delete();
    pay_q.push_back(id);
    pay_q.push_back(ptype);
    pay_q.push_back(tag);
    pay_q.push_back(cnt[7:0]);
    pay_q.push_back(cnt[15:8]);
    repeat (WORD_BYTES * nwords) pay_q.push_back(8'($urandom));
  endtask

  // Delimiter, big-endian length, type, filler/payload, then a checksum byte that
  // makes the sum from the type byte on come out to SUM_GOOD + sum_err.
  // Lengths that cannot fit in the store are cut at STORE_BYTES bytes.
  task automatic send_frame(input logic [7:0] ftype, input int len,
                            input logic [7:0] sum_err);
    int         nbytes;
    logic [7:0] acc;
    logic [7:0] b;
    nbytes = (len + 4 < STORE_BYTES_DEF) ? len + 4 : STORE_BYTES_DEF;
    acc    = 8'h00;
    for (int p = 0; p < nbytes; p++) begin
      if (p == 0) b = START_DELIM;
      else if (p == 1) b = len[15:8];
      else if (p == 2) b = len[7:0];
      else if (p == 3) b = ftype;              // zero-length frame: type is the sum
      else if (p == len + 3) b = SUM_GOOD - acc + sum_err;
      else if (p >= PAYLOAD_AT && p - PAYLOAD_AT < pay_q.size()) b = pay_q[p - PAYLOAD_AT];
      else b = 8'($urandom);
      if (p >= SUM_FROM) acc += b;
      send_byte(b);
    end
    n_frames++;
  endtask

  // Mostly well-formed frames with random content; some noise, truncated,
  // bad-sum and foreign-type frames mixed in.
  task automatic random_frame();
    int         r;
    int         nw;
    int         len;
    logic [7:0] ptype;
    logic [7:0] id;
    logic [7:0] ftype;
    logic [7:0] err;
    logic [7:0] nb;
    logic [15:0] cnt;
    r = $urandom_range(99);
    if (r < 8) begin
      // line noise between frames, never a delimiter
      repeat ($urandom_range(1, 6)) begin
        nb = 8'($urandom);
        if (nb == START_DELIM) nb = ~nb;
        send_byte(nb);
      end
    end else begin
      r     = $urandom_range(99);
      ptype = (r < 45) ? 8'h00 : (r < 85) ? 8'h01 : 8'($urandom_range(2, 255));
      id    = ($urandom_range(9) == 0) ? NO_ACK_ID : 8'($urandom);
      r     = $urandom_range(99);
      cnt   = (r < 70) ? 16'($urandom_range(3)) :
              (r < 88) ? 16'($urandom_range(4, 10)) : 16'($urandom_range(11, 65535));
      nw    = (ptype > 8'h01) ? 0 : (cnt > MAX_PARAMS_DEF) ? MAX_PARAMS_DEF : int'(cnt);
      load_payload(id, ptype, 8'($urandom), cnt, nw);
      len   = 16 + WORD_BYTES * nw + $urandom_range(3);
      // now and then cut short so the tail comes from older frames
      if ($urandom_range(19) == 0) len = $urandom_range(16 + WORD_BYTES * nw);
      ftype = ($urandom_range(9) == 0) ? cur_type ^ 8'($urandom_range(1, 255)) : cur_type;
      err   = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_frame(ftype, len, err);
    end
  endtask

  initial begin
    int b0;
    int r0;
    rst_n         = 1'b0;
    push          = 1'b0;
    in_rx_byte    = 8'h00;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    send_idle_pct = 21;
    recv_idle_pct = 74;
    cur_type      = FRAME_TYPE_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed cases ----
    // bytes before any delimiter are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h7D);
    // one-byte frame right after reset: payload reads all zero
    pay_q.delete();
    send_frame(cur_type, 1, 8'h00);
    // store fills before completion: dropped, then reception restarts
    pay_q.delete();
    send_frame(cur_type, STORE_BYTES_DEF - 4, 8'h00);
    // receiver holds off: a three-word frame backs up the dispatcher, and the
    // next frame stops at its first payload byte until results drain
    stall_len = 600;
    load_payload(8'h00, 8'h00, 8'hA5, 16'd3, 3);
    send_frame(cur_type, 28, 8'h00);
    // other packet kind, id 0xFF: no ack, tag and count forced to zero
    load_payload(NO_ACK_ID, 8'h02, 8'h33, 16'h0505, 0);
    send_frame(cur_type, 16, 8'h00);
    // car data, count far above the word limit; words come from older frames
    load_payload(8'h01, 8'h01, START_DELIM, 16'hFFFF, 0);
    send_frame(cur_type, 16, 8'h00);
    // bad checksum: silent
    load_payload(8'h11, 8'h00, 8'h22, 16'd2, 0);
    send_frame(cur_type, 16, 8'h01);
    // register extremes; zero-length frame whose type byte is the checksum
    write_frame_type(8'h00);
    send_frame(8'h00, 1, 8'h00);
    write_frame_type(8'hFF);
    send_frame(8'hFF, 0, 8'h00);

    // ---- random phases: sender/receiver idle 21/74, 74/21, then none ----
    for (int ph = 0; ph < 3; ph++) begin
      write_frame_type((ph == 1) ? FRAME_TYPE_RST : 8'($urandom));
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 21 : 0;
      b0 = n_bytes;
      r0 = n_predicted;
      while (n_bytes - b0 < 24 || n_predicted == r0) random_frame();
    end

    // sender waits for every outstanding result before finishing
    drain();

    $display("Sent %0d bytes in %0d frames; %0d result items predicted, %0d checked.",
             n_bytes, n_frames, n_predicted, n_checked);
    $display("Frame types reset/0x00/0xFF/random, idle mixes and a long receiver stall.");
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS api_frame_receiver_dispatch");
    end else begin
      $display("FAIL api_frame_receiver_dispatch");
    end
    $finish;
  end

endmodule

[api_frame_receiver_dispatch.f]
+incdir+design
design/afrd_pkg.sv
design/afrd_ram.sv
design/afrd_front.sv
design/afrd_back.sv
design/afrd_outq.sv
design/api_frame_receiver_dispatch.sv
dv/afrd_dispatch_checker.sv
dv/api_frame_receiver_dispatch_tb.sv
